[sv/cfr_pkg.sv]
// Package for the CEC follower responder: register indexes, CEC opcodes,
// job kinds and the structs shared by the front part, the queue and the back part.
// No dependencies.
package cfr_pkg;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LADDR    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PADDR    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT  = 3'd4;

    // Register reset values.
    localparam logic [3:0]  RST_LADDR    = 4'h4;
    localparam logic [15:0] RST_PADDR    = 16'h1000;
    localparam logic [15:0] RST_DEBOUNCE = 16'd50;
    localparam logic [15:0] RST_TIMEOUT  = 16'd500;

    // Received opcodes that are handled.
    localparam logic [7:0] OP_GIVE_PHYS    = 8'h83;
    localparam logic [7:0] OP_GIVE_NAME    = 8'h46;
    localparam logic [7:0] OP_GIVE_VENDOR  = 8'h8C;
    localparam logic [7:0] OP_GET_VERSION  = 8'h9F;
    localparam logic [7:0] OP_GIVE_POWER   = 8'h8F;
    localparam logic [7:0] OP_SET_STREAM   = 8'h86;
    localparam logic [7:0] OP_MENU_REQ     = 8'h8D;
    localparam logic [7:0] OP_UC_PRESS     = 8'h44;
    localparam logic [7:0] OP_UC_RELEASE   = 8'h45;
    localparam logic [7:0] OP_POLL         = 8'h00;

    // Reply opcodes and fixed operands.
    localparam logic [7:0] OP_REPORT_PHYS  = 8'h84;
    localparam logic [7:0] OP_SET_NAME     = 8'h47;
    localparam logic [7:0] OP_VENDOR_ID    = 8'h87;
    localparam logic [7:0] OP_CEC_VERSION  = 8'h9E;
    localparam logic [7:0] OP_POWER_STATUS = 8'h90;
    localparam logic [7:0] OP_ACTIVE_SRC   = 8'h82;
    localparam logic [7:0] OP_MENU_STATUS  = 8'h8E;
    localparam logic [7:0] DEV_PLAYBACK    = 8'h04;
    localparam logic [7:0] CEC_VERSION_14  = 8'h05;
    localparam logic [7:0] POWER_ON        = 8'h00;

    localparam logic [3:0] ADDR_BROADCAST  = 4'hF;
    localparam logic [3:0] ADDR_TV         = 4'h0;
    localparam logic [7:0] NO_BUTTON       = 8'hFF;
    localparam logic [4:0] MAX_FRAME_LEN   = 5'd16;

    // Job kinds handed from the front to the back.
    typedef logic [2:0] t_kind;
    localparam t_kind JOB_PHYS    = 3'd0;
    localparam t_kind JOB_NAME    = 3'd1;
    localparam t_kind JOB_VENDOR  = 3'd2;
    localparam t_kind JOB_VERSION = 3'd3;
    localparam t_kind JOB_POWER   = 3'd4;
    localparam t_kind JOB_PATH    = 3'd5;
    localparam t_kind JOB_MENU    = 3'd6;
    localparam t_kind JOB_KEY     = 3'd7;

    // Configuration register set.
    typedef struct packed {
        logic        enable;
        logic [3:0]  laddr;
        logic [15:0] paddr;
        logic [15:0] debounce;
        logic [15:0] timeout;
    } t_cfg;

    // One job: a reply frame or up to two key events. For reply frames hdr is
    // the header byte and b2/b3 carry variable operands; for key jobs b2 is the
    // released key and b3 the pressed key.
    typedef struct packed {
        t_kind      kind;
        logic [7:0] hdr;
        logic [7:0] b2;
        logic [7:0] b3;
        logic       rel;
        logic       press;
    } t_job;

endpackage

[sv/cfr_if.sv]
// Valid/ready channel interfaces for the CEC follower responder: the input
// channel carries received frames and ticks, the output channel the result words.
// No dependencies.
interface cfr_in_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] frame_header;
    logic [7:0] frame_opcode;
    logic [7:0] first_operand;
    logic [7:0] second_operand;
    logic [4:0] frame_length;

    modport source(
        output valid, action, frame_header, frame_opcode, first_operand,
               second_operand, frame_length,
        input  ready
    );
    modport sink(
        input  valid, action, frame_header, frame_opcode, first_operand,
               second_operand, frame_length,
        output ready
    );
endinterface

interface cfr_out_if;
    logic       valid;
    logic       ready;
    logic       result_kind;
    logic [7:0] tx_byte;
    logic [7:0] key_num;
    logic       key_pressed;
    logic       last;

    modport source(
        output valid, result_kind, tx_byte, key_num, key_pressed, last,
        input  ready
    );
    modport sink(
        input  valid, result_kind, tx_byte, key_num, key_pressed, last,
        output ready
    );
endinterface

[sv/cfr_front.sv]
// Front part of the CEC follower responder: accepts frames and ticks, keeps the
// millisecond and held-key state and turns each item into at most one job.
// Depends on cfr_pkg and cfr_if.
module cfr_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  cfr_pkg::t_cfg i_cfg,
    cfr_in_if.sink        i_in,
    input  logic          i_q_full,
    output logic          o_push,
    output cfr_pkg::t_job o_job
);
    import cfr_pkg::*;

    logic [31:0] r_ms, n_ms;
    logic [31:0] r_press_time, n_press_time;
    logic [7:0]  r_held_button, n_held_button;
    logic [7:0]  r_held_key, n_held_key;

    logic        accept;
    logic [31:0] ms_next;
    logic [31:0] elapsed_tick;
    logic [31:0] elapsed_now;
    logic [7:0]  opcode_eff;
    logic [7:0]  mapped;
    logic        len_ok;
    logic        dst_ok;
    logic        bounced;
    t_job        job;
    logic        push;

    // Remote-control button code to input key code; zero means unmapped.
    function automatic logic [7:0] map_button(input logic [7:0] code);
        logic [7:0] key;
        key = 8'd0;
        case (code)
            8'h01:        key = 8'd103;
            8'h02:        key = 8'd108;
            8'h03:        key = 8'd105;
            8'h04:        key = 8'd106;
            8'h00:        key = 8'd28;
            8'h09, 8'h0A: key = 8'd88;
            8'h0D:        key = 8'd1;
            8'h44, 8'h46: key = 8'd57;
            8'h45:        key = 8'd31;
            8'h49:        key = 8'd33;
            8'h48:        key = 8'd19;
            8'h41:        key = 8'd13;
            8'h42:        key = 8'd12;
            8'h43:        key = 8'd50;
            8'h40:        key = 8'd25;
            default:      key = 8'd0;
        endcase
        return key;
    endfunction

    assign i_in.ready = !i_q_full;
    assign accept     = i_in.valid && !i_q_full;

    // Frame checks and elapsed-time arithmetic.
    assign ms_next      = r_ms + 32'd1;
    assign elapsed_tick = ms_next - r_press_time;
    assign elapsed_now  = r_ms - r_press_time;
    assign opcode_eff   = (i_in.frame_length == 5'd1) ? OP_POLL : i_in.frame_opcode;
    assign mapped       = map_button(i_in.first_operand);
    assign len_ok       = (i_in.frame_length != 5'd0) && (i_in.frame_length <= MAX_FRAME_LEN);
    assign dst_ok       = (i_in.frame_header[3:0] == i_cfg.laddr)
                       || (i_in.frame_header[3:0] == ADDR_BROADCAST);
    assign bounced      = (i_in.first_operand == r_held_button)
                       && (elapsed_now < {16'h0, i_cfg.debounce});

    // Classification and state update.
    always_comb begin
        n_ms          = r_ms;
        n_press_time  = r_press_time;
        n_held_button = r_held_button;
        n_held_key    = r_held_key;
        job           = '0;
        push          = 1'b0;
        if (accept && i_cfg.enable) begin
            if (i_in.action) begin
                // Millisecond tick with auto-release check.
                n_ms = ms_next;
                if (r_held_key != 8'd0 && elapsed_tick >= {16'h0, i_cfg.timeout}) begin
                    job.kind      = JOB_KEY;
                    job.rel       = 1'b1;
                    job.b2        = r_held_key;
                    push          = 1'b1;
                    n_held_key    = 8'd0;
                    n_held_button = NO_BUTTON;
                    n_press_time  = 32'd0;
                end
            end else if (len_ok && dst_ok) begin
                unique case (opcode_eff)
                    OP_GIVE_PHYS: begin
                        job.kind = JOB_PHYS;
                        job.hdr  = {i_cfg.laddr, ADDR_BROADCAST};
                        job.b2   = i_cfg.paddr[15:8];
                        job.b3   = i_cfg.paddr[7:0];
                        push     = 1'b1;
                    end
                    OP_GIVE_NAME: begin
                        job.kind = JOB_NAME;
                        job.hdr  = {i_cfg.laddr, ADDR_TV};
                        push     = 1'b1;
                    end
                    OP_GIVE_VENDOR: begin
                        job.kind = JOB_VENDOR;
                        job.hdr  = {i_cfg.laddr, ADDR_BROADCAST};
                        push     = 1'b1;
                    end
                    OP_GET_VERSION: begin
                        job.kind = JOB_VERSION;
                        job.hdr  = {i_cfg.laddr, i_in.frame_header[7:4]};
                        push     = 1'b1;
                    end
                    OP_GIVE_POWER: begin
                        job.kind = JOB_POWER;
                        job.hdr  = {i_cfg.laddr, i_in.frame_header[7:4]};
                        push     = 1'b1;
                    end
                    OP_SET_STREAM: begin
                        if (i_in.frame_length >= 5'd4
                            && {i_in.first_operand, i_in.second_operand} == i_cfg.paddr) begin
                            job.kind = JOB_PATH;
                            job.hdr  = {i_cfg.laddr, ADDR_BROADCAST};
                            job.b2   = i_cfg.paddr[15:8];
                            job.b3   = i_cfg.paddr[7:0];
                            push     = 1'b1;
                        end
                    end
                    OP_MENU_REQ: begin
                        if (i_in.frame_length >= 5'd3) begin
                            job.kind = JOB_MENU;
                            job.hdr  = {i_cfg.laddr, i_in.frame_header[7:4]};
                            job.b2   = {7'd0, (i_in.first_operand != 8'd0)};
                            push     = 1'b1;
                        end
                    end
                    OP_UC_PRESS: begin
                        // A new key releases a different held key first.
                        if (i_in.frame_length >= 5'd3 && !bounced && mapped != 8'd0) begin
                            job.kind      = JOB_KEY;
                            job.rel       = (r_held_key != 8'd0) && (r_held_key != mapped);
                            job.b2        = r_held_key;
                            job.press     = 1'b1;
                            job.b3        = mapped;
                            push          = 1'b1;
                            n_held_button = i_in.first_operand;
                            n_held_key    = mapped;
                            n_press_time  = r_ms;
                        end
                    end
                    OP_UC_RELEASE: begin
                        if (r_held_key != 8'd0) begin
                            job.kind      = JOB_KEY;
                            job.rel       = 1'b1;
                            job.b2        = r_held_key;
                            push          = 1'b1;
                            n_held_key    = 8'd0;
                            n_held_button = NO_BUTTON;
                            n_press_time  = 32'd0;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    assign o_push = push;
    assign o_job  = job;

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ms          <= 32'd0;
            r_press_time  <= 32'd0;
            r_held_button <= NO_BUTTON;
            r_held_key    <= 8'd0;
        end else begin
            r_ms          <= n_ms;
            r_press_time  <= n_press_time;
            r_held_button <= n_held_button;
            r_held_key    <= n_held_key;
        end
    end

endmodule

[sv/cfr_queue.sv]
// Job queue between the front and back parts of the CEC follower responder.
// Depends on cfr_pkg.
module cfr_queue #(
    parameter int DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  cfr_pkg::t_job i_job,
    input  logic          i_pop,
    output cfr_pkg::t_job o_head,
    output logic          o_empty,
    output logic          o_full
);
    import cfr_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    assign o_empty = (r_count == CNT_W'(0));
    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_head  = r_mem[r_rd_ptr];

    // Pointer and fill-count update.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

[sv/cfr_back.sv]
// Back part of the CEC follower responder: expands the job at the queue head
// into result words, one a cycle while o_out is ready, via an output register.
// Depends on cfr_pkg and cfr_if.
module cfr_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  cfr_pkg::t_job i_job,
    input  logic          i_q_empty,
    output logic          o_pop,
    cfr_out_if.source     o_out
);
    import cfr_pkg::*;

    logic [2:0] r_idx, n_idx;
    logic       r_valid;
    logic       r_kind;
    logic [7:0] r_tx_byte;
    logic [7:0] r_key_num;
    logic       r_key_pressed;
    logic       r_last;

    logic       advance;
    logic       is_last;
    logic [3:0] job_len;
    logic       res_kind;
    logic [7:0] res_byte;
    logic [7:0] res_key;
    logic       res_down;

    // Fixed on-screen name, six bytes.
    function automatic logic [7:0] name_byte(input logic [2:0] idx);
        logic [7:0] b;
        b = 8'h00;
        case (idx)
            3'd2:    b = 8'h4D;
            3'd3:    b = 8'h69;
            3'd4:    b = 8'h53;
            3'd5:    b = 8'h54;
            3'd6:    b = 8'h65;
            3'd7:    b = 8'h72;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    // Number of result words a job yields.
    always_comb begin
        unique case (i_job.kind)
            JOB_PHYS:    job_len = 4'd5;
            JOB_NAME:    job_len = 4'd8;
            JOB_VENDOR:  job_len = 4'd5;
            JOB_VERSION: job_len = 4'd3;
            JOB_POWER:   job_len = 4'd3;
            JOB_PATH:    job_len = 4'd4;
            JOB_MENU:    job_len = 4'd3;
            JOB_KEY:     job_len = {3'd0, i_job.rel} + {3'd0, i_job.press};
            default:     job_len = 4'd1;
        endcase
    end

    // Result word at the current index.
    always_comb begin
        res_kind = 1'b0;
        res_byte = 8'h00;
        res_key  = 8'h00;
        res_down = 1'b0;
        if (i_job.kind == JOB_KEY) begin
            res_kind = 1'b1;
            if (i_job.rel && r_idx == 3'd0) begin
                res_key = i_job.b2;
            end else begin
                res_key  = i_job.b3;
                res_down = 1'b1;
            end
        end else if (r_idx == 3'd0) begin
            res_byte = i_job.hdr;
        end else if (r_idx == 3'd1) begin
            unique case (i_job.kind)
                JOB_PHYS:    res_byte = OP_REPORT_PHYS;
                JOB_NAME:    res_byte = OP_SET_NAME;
                JOB_VENDOR:  res_byte = OP_VENDOR_ID;
                JOB_VERSION: res_byte = OP_CEC_VERSION;
                JOB_POWER:   res_byte = OP_POWER_STATUS;
                JOB_PATH:    res_byte = OP_ACTIVE_SRC;
                JOB_MENU:    res_byte = OP_MENU_STATUS;
                default:     res_byte = 8'h00;
            endcase
        end else begin
            unique case (i_job.kind)
                JOB_PHYS: begin
                    res_byte = (r_idx == 3'd2) ? i_job.b2
                             : (r_idx == 3'd3) ? i_job.b3 : DEV_PLAYBACK;
                end
                JOB_PATH:    res_byte = (r_idx == 3'd2) ? i_job.b2 : i_job.b3;
                JOB_NAME:    res_byte = name_byte(r_idx);
                JOB_VERSION: res_byte = CEC_VERSION_14;
                JOB_POWER:   res_byte = POWER_ON;
                JOB_MENU:    res_byte = i_job.b2;
                default:     res_byte = 8'h00;
            endcase
        end
    end

    assign is_last = ({1'b0, r_idx} == job_len - 4'd1);
    assign advance = !i_q_empty && (!r_valid || o_out.ready);
    assign o_pop   = advance && is_last;
    assign n_idx   = is_last ? 3'd0 : r_idx + 3'd1;

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= 3'd0;
            r_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_idx <= n_idx;
            end
            if (advance) begin
                r_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Output payload register.
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_kind        <= res_kind;
            r_tx_byte     <= res_byte;
            r_key_num     <= res_key;
            r_key_pressed <= res_down;
            r_last        <= is_last;
        end
    end

    assign o_out.valid       = r_valid;
    assign o_out.result_kind = r_kind;
    assign o_out.tx_byte     = r_tx_byte;
    assign o_out.key_num     = r_key_num;
    assign o_out.key_pressed = r_key_pressed;
    assign o_out.last        = r_last;

endmodule

[sv/cec_follower_responder_unit.sv]
// Top level of the CEC follower responder: configuration registers, front part,
// job queue and back part. Depends on cfr_pkg, cfr_if, cfr_front, cfr_queue, cfr_back.
//
// The block takes received CEC frames and millisecond ticks on i_in and gives
// reply frame bytes and key events on o_out, one word per cycle while o_out is
// ready, the last word of each job marked. An item that causes results yields a
// job that waits in a QUEUE_DEPTH deep queue, so the input keeps flowing while
// the back part is busy, until the queue fills. A job yields one to eight words
// (eight for the OSD name reply) and the output word rate sets the sustained
// throughput. The user must write configuration through i_cfg_we, i_cfg_index
// and i_cfg_data only while the block is idle; the block does not enforce this.
module cec_follower_responder_unit #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [cfr_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]                   i_cfg_data,
    cfr_in_if.sink                        i_in,
    cfr_out_if.source                     o_out
);
    import cfr_pkg::*;

    t_cfg r_cfg;
    t_job front_job;
    t_job head_job;
    logic q_push;
    logic q_pop;
    logic q_empty;
    logic q_full;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enable   <= 1'b0;
            r_cfg.laddr    <= RST_LADDR;
            r_cfg.paddr    <= RST_PADDR;
            r_cfg.debounce <= RST_DEBOUNCE;
            r_cfg.timeout  <= RST_TIMEOUT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ENABLE:   r_cfg.enable   <= i_cfg_data[0];
                CFG_LADDR:    r_cfg.laddr    <= i_cfg_data[3:0];
                CFG_PADDR:    r_cfg.paddr    <= i_cfg_data;
                CFG_DEBOUNCE: r_cfg.debounce <= i_cfg_data;
                CFG_TIMEOUT:  r_cfg.timeout  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    cfr_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_in     (i_in),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_job    (front_job)
    );

    cfr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (front_job),
        .i_pop   (q_pop),
        .o_head  (head_job),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    cfr_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_job     (head_job),
        .i_q_empty (q_empty),
        .o_pop     (q_pop),
        .o_out     (o_out)
    );

`ifndef ASSERT_OFF
    // The front never pushes a job into a full queue.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_full |-> !q_push)
        else $error("job pushed into a full queue");

    // The back never pops an empty queue.
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_empty)
        else $error("job popped from an empty queue");

    // A disabled block creates no jobs.
    a_disabled_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_cfg.enable |-> !q_push)
        else $error("job created while the block is disabled");
`endif

endmodule
